@@ design/bloom_filter_insert_query_core_assert.svh @@
// Assertion macros for the bloom filter core.
// Needs a clock named clock and a reset named reset in the including module.
`ifndef BLOOM_FILTER_INSERT_QUERY_CORE_ASSERT_SVH
`define BLOOM_FILTER_INSERT_QUERY_CORE_ASSERT_SVH

// same-cycle implication
`define BFIQ_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BFIQ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/bfiq_pkg.sv @@
// Shared types and constants of the bloom filter core.
// No dependencies.
package bfiq_pkg;

   localparam int KEY_BYTE_W   = 8;
   localparam int BIT_COUNT_W  = 13;
   localparam int HASH_COUNT_W = 3;
   localparam int CSR_INDEX_W  = 8;
   localparam int CSR_DATA_W   = 13;
   localparam int HASH_W       = 64;
   localparam int HALF_W       = 32;
   localparam int FOLD_SHIFT   = 32;
   localparam int DIV_CNT_W    = 6;

   localparam logic [HASH_W-1:0] GOLDEN = 64'h9e3779b97f4a7c15;
   localparam logic [HASH_W-1:0] MIXER  = 64'h517cc1b727220a95;

   localparam logic [BIT_COUNT_W-1:0]  BIT_COUNT_RESET  = 13'd4096;
   localparam logic [HASH_COUNT_W-1:0] HASH_COUNT_RESET = 3'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_BIT_COUNT  = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HASH_COUNT = 8'd1;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_XOR, ST_MUL_LL, ST_MUL_HL, ST_MUL_LH, ST_FOLD,
      ST_END, ST_DIV, ST_BIT, ST_TEST, ST_DONE
   } state_type;

   typedef struct packed {
      logic load_item;
      logic hidx_clr;
      logic hidx_inc;
      logic x_load;
      logic p_load;
      logic hi_init;
      logic hi_acc;
      logic mul_xhi;
      logic mul_mhi;
      logic fold;
      logic div_start;
      logic div_step;
      logic clr_step;
      logic mem_clear;
      logic mem_set;
      logic present_clr;
      logic out_load;
      logic reseed;
   } cmd_type;

   typedef struct packed {
      logic last;
      logic kind;
      logic hash_last;
      logic end_done;
      logic div_last;
      logic clr_last;
      logic bit_set;
   } status_type;

endpackage

@@ design/bfiq_ifs.sv @@
// Valid/ready channels of the bloom filter core: request, response, register write.
// Depends on bfiq_pkg.
interface bfiq_req_if import bfiq_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  kind;
   logic [KEY_BYTE_W-1:0] key_byte;
   logic                  has_byte;
   logic                  last;
   modport source (output valid, kind, key_byte, has_byte, last, input ready);
   modport sink   (input valid, kind, key_byte, has_byte, last, output ready);
endinterface

interface bfiq_rsp_if;
   logic valid;
   logic ready;
   logic maybe_present;
   logic was_query;
   modport source (output valid, maybe_present, was_query, input ready);
   modport sink   (input valid, maybe_present, was_query, output ready);
endinterface

interface bfiq_csr_if import bfiq_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ design/bfiq_ram.sv @@
// Generic single-port RAM with registered read.
// No dependencies.
module bfiq_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;
endmodule

@@ design/bfiq_datapath.sv @@
// Datapath: running hashes, shared 32x32 multiplier, remainder unit, filter RAM,
// registers and response word. Depends on bfiq_pkg, bfiq_ram.
module bfiq_datapath import bfiq_pkg::*; #(
   parameter int MAX_BITS   = 4096,
   parameter int MAX_HASHES = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output status_type              st,
   input  logic                    req_kind,
   input  logic [KEY_BYTE_W-1:0]   req_key_byte,
   input  logic                    req_last,
   input  logic                    csr_we,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data,
   output logic                    maybe_present,
   output logic                    was_query
);
   localparam int ADDR_W = $clog2(MAX_BITS);
   localparam int MOD_W  = $clog2(MAX_BITS + 1);
   localparam int CNT_W  = $clog2(MAX_HASHES + 1);
   localparam int HSEL_W = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;

   logic [BIT_COUNT_W-1:0]  bit_count_ff;
   logic [HASH_COUNT_W-1:0] hash_count_ff;
   logic [HASH_W-1:0]       h_ff [MAX_HASHES];
   logic [HASH_W-1:0]       seed [MAX_HASHES];
   logic [CNT_W-1:0]        hidx_ff;
   logic                    kind_ff, last_ff, present_ff;
   logic [KEY_BYTE_W-1:0]   byte_ff;
   logic [HASH_W-1:0]       x_ff, p_ff, sh_ff;
   logic [HALF_W-1:0]       hi_ff;
   logic [MOD_W-1:0]        rem_ff;
   logic [DIV_CNT_W-1:0]    dcnt_ff;
   logic [ADDR_W-1:0]       clr_addr_ff;
   logic                    maybe_ff, wasq_ff;

   logic [HASH_W-1:0]       h_sel, byte_sext, prod;
   logic [HALF_W-1:0]       opa, opb;
   logic [MOD_W-1:0]        mod_eff;
   logic [CNT_W-1:0]        hashes_eff;
   logic [MOD_W:0]          trial;
   logic [MOD_W-1:0]        rem_next;
   logic                    ram_we, ram_rdata;
   logic [ADDR_W-1:0]       ram_addr;

   for (genvar i = 0; i < MAX_HASHES; i++) begin : g_seed
      assign seed[i] = HASH_W'(64'(i) * GOLDEN);
   end

   assign h_sel     = h_ff[hidx_ff[HSEL_W-1:0]];
   assign byte_sext = {{(HASH_W-KEY_BYTE_W){byte_ff[KEY_BYTE_W-1]}}, byte_ff};
   assign opa       = cmd.mul_xhi ? x_ff[HASH_W-1:HALF_W] : x_ff[HALF_W-1:0];
   assign opb       = cmd.mul_mhi ? MIXER[HASH_W-1:HALF_W] : MIXER[HALF_W-1:0];
   assign prod      = {{HALF_W{1'b0}}, opa} * {{HALF_W{1'b0}}, opb};

   always_comb begin
      if (bit_count_ff == '0) begin
         mod_eff = MOD_W'(1);
      end else if (32'(bit_count_ff) > 32'(MAX_BITS)) begin
         mod_eff = MOD_W'(MAX_BITS);
      end else begin
         mod_eff = MOD_W'(bit_count_ff);
      end
      if (32'(hash_count_ff) > 32'(MAX_HASHES)) begin
         hashes_eff = CNT_W'(MAX_HASHES);
      end else begin
         hashes_eff = CNT_W'(hash_count_ff);
      end
   end

   // one remainder bit per cycle
   assign trial    = {rem_ff, sh_ff[HASH_W-1]};
   assign rem_next = (trial >= {1'b0, mod_eff}) ? MOD_W'(trial - {1'b0, mod_eff})
                                                : trial[MOD_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_count_ff  <= BIT_COUNT_RESET;
         hash_count_ff <= HASH_COUNT_RESET;
         hidx_ff       <= '0;
         clr_addr_ff   <= '0;
         for (int i = 0; i < MAX_HASHES; i++) begin
            h_ff[i] <= seed[i];
         end
      end else begin
         if (csr_we && csr_index == CSR_BIT_COUNT) begin
            bit_count_ff <= csr_data;
         end
         if (csr_we && csr_index == CSR_HASH_COUNT) begin
            hash_count_ff <= csr_data[HASH_COUNT_W-1:0];
         end
         if (cmd.load_item || cmd.hidx_clr) begin
            hidx_ff <= '0;
         end else if (cmd.hidx_inc) begin
            hidx_ff <= hidx_ff + CNT_W'(1);
         end
         if (cmd.clr_step) begin
            clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
         end
         if (cmd.fold) begin
            h_ff[hidx_ff[HSEL_W-1:0]] <= {hi_ff, p_ff[HALF_W-1:0] ^ hi_ff};
         end else if (cmd.reseed) begin
            for (int i = 0; i < MAX_HASHES; i++) begin
               h_ff[i] <= seed[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         kind_ff    <= req_kind;
         byte_ff    <= req_key_byte;
         last_ff    <= req_last;
         present_ff <= 1'b1;
      end else if (cmd.present_clr) begin
         present_ff <= 1'b0;
      end
      if (cmd.x_load) begin
         x_ff <= h_sel ^ byte_sext;
      end
      if (cmd.p_load) begin
         p_ff <= prod;
      end
      if (cmd.hi_init) begin
         hi_ff <= p_ff[HASH_W-1:FOLD_SHIFT] + prod[HALF_W-1:0];
      end else if (cmd.hi_acc) begin
         hi_ff <= hi_ff + prod[HALF_W-1:0];
      end
      if (cmd.div_start) begin
         sh_ff   <= h_sel;
         rem_ff  <= '0;
         dcnt_ff <= '0;
      end else if (cmd.div_step) begin
         sh_ff   <= {sh_ff[HASH_W-2:0], 1'b0};
         rem_ff  <= rem_next;
         dcnt_ff <= dcnt_ff + DIV_CNT_W'(1);
      end
      if (cmd.out_load) begin
         maybe_ff <= present_ff;
         wasq_ff  <= kind_ff;
      end
   end

   assign ram_we   = cmd.mem_clear || cmd.mem_set;
   assign ram_addr = cmd.mem_clear ? clr_addr_ff : rem_ff[ADDR_W-1:0];

   bfiq_ram #(.WIDTH(1), .DEPTH(MAX_BITS)) u_bits (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (cmd.mem_set),
      .rdata (ram_rdata)
   );

   assign st.last      = last_ff;
   assign st.kind      = kind_ff;
   assign st.hash_last = (hidx_ff == CNT_W'(MAX_HASHES - 1));
   assign st.end_done  = (hidx_ff >= hashes_eff);
   assign st.div_last  = (dcnt_ff == '1);
   assign st.clr_last  = (clr_addr_ff == ADDR_W'(MAX_BITS - 1));
   assign st.bit_set   = ram_rdata;

   assign maybe_present = maybe_ff;
   assign was_query     = wasq_ff;
endmodule

@@ design/bfiq_ctrl.sv @@
// Controller state machine: sequences hashing, index reduction, filter access, response.
// Depends on bfiq_pkg and the assertion macro header.
`include "bloom_filter_insert_query_core_assert.svh"
module bfiq_ctrl import bfiq_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_has_byte,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type st,
   output cmd_type    cmd
);
   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_CLEAR: begin
            cmd.mem_clear = 1'b1;
            cmd.clr_step  = 1'b1;
            if (st.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               if (req_has_byte) begin
                  state_in = ST_XOR;
               end else if (req_last) begin
                  state_in = ST_END;
               end
            end
         end
         ST_XOR: begin
            cmd.x_load = 1'b1;
            state_in   = ST_MUL_LL;
         end
         ST_MUL_LL: begin
            cmd.p_load = 1'b1;
            state_in   = ST_MUL_HL;
         end
         ST_MUL_HL: begin
            cmd.mul_xhi = 1'b1;
            cmd.hi_init = 1'b1;
            state_in    = ST_MUL_LH;
         end
         ST_MUL_LH: begin
            cmd.mul_mhi = 1'b1;
            cmd.hi_acc  = 1'b1;
            state_in    = ST_FOLD;
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
            if (st.hash_last) begin
               cmd.hidx_clr = 1'b1;
               state_in     = st.last ? ST_END : ST_IDLE;
            end else begin
               cmd.hidx_inc = 1'b1;
               state_in     = ST_XOR;
            end
         end
         ST_END: begin
            if (st.end_done) begin
               state_in = ST_DONE;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (st.div_last) begin
               state_in = ST_BIT;
            end
         end
         ST_BIT: begin
            if (st.kind) begin
               state_in     = ST_TEST;
            end else begin
               cmd.mem_set  = 1'b1;
               cmd.hidx_inc = 1'b1;
               state_in     = ST_END;
            end
         end
         ST_TEST: begin
            if (!st.bit_set) begin
               cmd.present_clr = 1'b1;
               state_in        = ST_DONE;
            end else begin
               cmd.hidx_inc = 1'b1;
               state_in     = ST_END;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               cmd.reseed   = 1'b1;
               cmd.hidx_clr = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   `BFIQ_ASSERT_NEXT(a_div_to_bit, state_ff == ST_DIV && st.div_last, state_ff == ST_BIT, "remainder did not hand over to bit access")
   `BFIQ_ASSERT_NEXT(a_done_shows, state_ff == ST_DONE && out_free, rsp_valid_ff, "finished key produced no response word")
   `BFIQ_ASSERT_NOW(a_clear_blocks, state_ff == ST_CLEAR, !req_ready && !rsp_valid_ff, "request taken during clearing pass")
   `BFIQ_ASSERT_NEXT(a_fold_loop, state_ff == ST_FOLD && !st.hash_last, state_ff == ST_XOR, "hash loop left early")
endmodule

@@ design/bloom_filter_insert_query_core.sv @@
// Top level of the bloom filter core: controller, datapath and channel wiring.
// Depends on bfiq_pkg, bfiq_ifs, bfiq_ctrl, bfiq_datapath.
//
//   channel  direction  word
//   req_chan in         kind, key_byte, has_byte, last
//   rsp_chan out        maybe_present, was_query
//   csr_chan in         index (0 bit_count, 1 hash_count), data
//
// A key byte runs, per hash, XOR, three 32x32 multiplies on the one shared
// multiplier and the fold. A key end adds, per hash in use, a bit-serial remainder
// over the 64 hash bits and a filter RAM access, plus a bit test for a query.
// After reset a clearing pass zeroes the filter; no request is taken.
// A pending response holds in its register while the next request is taken.
module bloom_filter_insert_query_core import bfiq_pkg::*; #(
   parameter int MAX_BITS   = 4096,
   parameter int MAX_HASHES = 4
) (
   input  logic        clock,
   input  logic        reset,
   bfiq_req_if.sink    req_chan,
   bfiq_rsp_if.source  rsp_chan,
   bfiq_csr_if.sink    csr_chan
);
   cmd_type    cmd;
   status_type st;

   assign csr_chan.ready = 1'b1;

   bfiq_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_chan.valid),
      .req_ready    (req_chan.ready),
      .req_has_byte (req_chan.has_byte),
      .req_last     (req_chan.last),
      .rsp_valid    (rsp_chan.valid),
      .rsp_ready    (rsp_chan.ready),
      .st           (st),
      .cmd          (cmd)
   );

   bfiq_datapath #(.MAX_BITS(MAX_BITS), .MAX_HASHES(MAX_HASHES)) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .st            (st),
      .req_kind      (req_chan.kind),
      .req_key_byte  (req_chan.key_byte),
      .req_last      (req_chan.last),
      .csr_we        (csr_chan.valid),
      .csr_index     (csr_chan.index),
      .csr_data      (csr_chan.data),
      .maybe_present (rsp_chan.maybe_present),
      .was_query     (rsp_chan.was_query)
   );
endmodule
